/* rtl/qau_pkg.sv */
// Shared types, codes and sizes of the quaternion arithmetic unit.
package qau_pkg;

  localparam int WORD_W   = 32;
  localparam int FRAC     = 30;
  localparam int ACC_W    = 2 * WORD_W + 4;
  localparam int RAD_W    = 2 * WORD_W + 2;
  localparam int ROOT_W   = WORD_W + 1;
  localparam int REM_W    = ROOT_W + 3;
  localparam int SQ_STEPS = RAD_W / 2;
  localparam int QUO_W    = WORD_W;
  localparam int DEN_W    = ROOT_W + 1;
  localparam int NUM_W    = RAD_W;

  localparam logic [1:0] MODE_MUL  = 2'd0;
  localparam logic [1:0] MODE_NORM = 2'd1;
  localparam logic [1:0] MODE_MAT  = 2'd2;
  localparam logic [1:0] MODE_INV  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [WORD_W-1:0] a_w;
    logic signed [WORD_W-1:0] a_x;
    logic signed [WORD_W-1:0] a_y;
    logic signed [WORD_W-1:0] a_z;
    logic signed [WORD_W-1:0] b_w;
    logic signed [WORD_W-1:0] b_x;
    logic signed [WORD_W-1:0] b_y;
    logic signed [WORD_W-1:0] b_z;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] res_0;
    logic signed [WORD_W-1:0] res_1;
    logic signed [WORD_W-1:0] res_2;
    logic signed [WORD_W-1:0] res_3;
    logic signed [WORD_W-1:0] res_4;
    logic signed [WORD_W-1:0] res_5;
    logic signed [WORD_W-1:0] res_6;
    logic signed [WORD_W-1:0] res_7;
    logic signed [WORD_W-1:0] res_8;
    logic [1:0]               status;
  } out_t;

  // Everything an item carries alongside the square root and divide.
  typedef struct packed {
    logic [1:0]             mode;
    logic [8:0][WORD_W-1:0] res;
    logic                   sat;
    logic                   zero;
    logic [3:0][WORD_W-1:0] mag;
    logic [3:0]             neg;
  } side_t;

endpackage

/* rtl/qau_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module qau_sqrt (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [qau_pkg::RAD_W-1:0]              radicand_i,
  input  qau_pkg::side_t                         side_i,
  output logic                                   valid_o,
  output logic [qau_pkg::ROOT_W-1:0]             root_o,
  output qau_pkg::side_t                         side_o
);

  typedef struct packed {
    logic [qau_pkg::RAD_W-1:0]  sh;
    logic [qau_pkg::REM_W-1:0]  rem;
    logic [qau_pkg::ROOT_W-1:0] root;
    qau_pkg::side_t             side;
  } sq_t;

  localparam int RW = qau_pkg::REM_W;
  localparam int DW = qau_pkg::RAD_W;
  localparam int OW = qau_pkg::ROOT_W;

  sq_t  st_q  [qau_pkg::SQ_STEPS];
  logic vld_q [qau_pkg::SQ_STEPS];

  for (genvar k = 0; k < qau_pkg::SQ_STEPS; k++) begin : g_st
    sq_t           cur;
    sq_t           nxt;
    logic          cur_v;
    logic [RW-1:0] rt;
    logic [RW-1:0] trial;
    logic [RW:0]   diff;

    if (k == 0) begin : g_first
      always_comb begin
        cur.sh   = radicand_i;
        cur.rem  = '0;
        cur.root = '0;
        cur.side = side_i;
        cur_v    = valid_i;
      end
    end else begin : g_next
      always_comb begin
        cur   = st_q[k-1];
        cur_v = vld_q[k-1];
      end
    end

    // Bring down the next two radicand bits and try root*4+1.
    always_comb begin
      rt    = {cur.rem[RW-3:0], cur.sh[DW-1:DW-2]};
      trial = {1'b0, cur.root, 2'b01};
      diff  = {1'b0, rt} - {1'b0, trial};
      nxt    = cur;
      nxt.sh = {cur.sh[DW-3:0], 2'b00};
      if (!diff[RW]) begin
        nxt.rem  = diff[RW-1:0];
        nxt.root = {cur.root[OW-2:0], 1'b1};
      end else begin
        nxt.rem  = rt;
        nxt.root = {cur.root[OW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign valid_o = vld_q[qau_pkg::SQ_STEPS-1];
  assign root_o  = st_q[qau_pkg::SQ_STEPS-1].root;
  assign side_o  = st_q[qau_pkg::SQ_STEPS-1].side;

endmodule

/* rtl/qau_div.sv */
// Pipelined restoring divide of four magnitudes by twice the root.
module qau_div (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic [qau_pkg::ROOT_W-1:0]                 root_i,
  input  qau_pkg::side_t                             side_i,
  output logic                                       valid_o,
  output logic [3:0][qau_pkg::QUO_W-1:0]             quo_o,
  output qau_pkg::side_t                             side_o
);

  localparam int NW = qau_pkg::NUM_W;
  localparam int QW = qau_pkg::QUO_W;
  localparam int WW = qau_pkg::WORD_W;

  typedef struct packed {
    logic [3:0][NW-1:0]         rem;
    logic [3:0][QW-1:0]         quo;
    logic [qau_pkg::DEN_W-1:0]  den;
    qau_pkg::side_t             side;
  } dv_t;

  dv_t  st_q  [QW+1];
  logic vld_q [QW+1];
  dv_t  first_d;

  // Numerator is |a| * 2^(FRAC+1) + r, so the quotient rounds half away.
  always_comb begin
    first_d.side = side_i;
    first_d.den  = {root_i, 1'b0};
    first_d.quo  = '0;
    for (int i = 0; i < 4; i++) begin
      first_d.rem[i] = {{(NW-WW-qau_pkg::FRAC-1){1'b0}}, side_i.mag[i],
                        {(qau_pkg::FRAC+1){1'b0}}}
                       + NW'(root_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= first_d;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_st
    localparam int K = QW - s;
    dv_t           nxt;
    logic [NW-1:0] dsh;
    logic [NW:0]   diff [4];

    always_comb begin
      nxt = st_q[s-1];
      dsh = NW'(st_q[s-1].den) << K;
      for (int i = 0; i < 4; i++) begin
        diff[i] = {1'b0, st_q[s-1].rem[i]} - {1'b0, dsh};
        if (!diff[i][NW]) begin
          nxt.rem[i]    = diff[i][NW-1:0];
          nxt.quo[i][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= nxt;
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = st_q[QW].quo;
  assign side_o  = st_q[QW].side;

endmodule

/* rtl/quaternion_arith_unit.sv */
// Quaternion arithmetic unit top: product, normalize, matrix, inverse matrix modes.
//
// One input beat carries a mode code and quaternions a and b in signed Q1.30;
// one output beat carries nine result words and a status code. Both channels
// use valid/ready. Every accepted beat gives exactly one result beat, in order.
// Every mode takes the same path from input accept to output valid:
// one product stage, one sum stage, 33 square root stages (the first also
// rounds and saturates the product sums), 33 divide stages and the output
// register. The square root and divide chains set its length; all modes
// follow them so results stay in order.
// Throughput is one beat per cycle while the receiver keeps up. The whole pipeline advances together:
// it moves whenever the output register is empty or being taken, so a beat
// can enter while a finished result is being taken, and a stalled receiver freezes
// every stage without losing or repeating a beat.
// Reset clears all valid bits; no beat is in flight afterwards.
// Normalizing an all-zero quaternion returns zeros with the zero status.
module quaternion_arith_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  qau_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output qau_pkg::out_t out_data_o
);

  localparam int WW = qau_pkg::WORD_W;
  localparam int AW = qau_pkg::ACC_W;
  localparam int QW = qau_pkg::QUO_W;

  logic en;

  // Stage 1: sixteen products.
  logic signed [WW-1:0]   a_arr  [4];
  logic signed [WW-1:0]   op_arr [4];
  logic signed [2*WW-1:0] prod_d [4][4];
  logic signed [2*WW-1:0] prod_q [4][4];
  logic [3:0][WW-1:0]     mag_d, mag1_q, mag2_q;
  logic [3:0]             neg_d, neg1_q, neg2_q;
  logic [1:0]             mode1_q, mode2_q;
  logic                   vld1_q, vld2_q;

  // Stage 2: exact sums.
  logic signed [AW-1:0]        e [4][4];
  logic signed [AW-1:0]        c01, c02, c03;
  logic signed [AW-1:0]        acc_d [9];
  logic signed [AW-1:0]        acc_q [9];
  logic [qau_pkg::RAD_W-1:0]   rad_d, rad_q;

  // Stage 3 and beyond.
  qau_pkg::side_t              side3_d;
  logic [8:0]                  satv;
  logic [WW:0]                 rs [9];
  logic                        sq_vld;
  logic [qau_pkg::ROOT_W-1:0]  sq_root;
  qau_pkg::side_t              sq_side;
  logic                        dv_vld;
  logic [3:0][QW-1:0]          dv_quo;
  qau_pkg::side_t              dv_side;

  logic signed [QW+1:0]        nval [4];
  logic [3:0][WW-1:0]          nres;
  logic [3:0]                  nsat;
  logic [8:0][WW-1:0]          fin;
  logic [1:0]                  fin_status;
  qau_pkg::out_t               out_d, out_q;
  logic                        out_vld_q;

  function automatic logic [WW:0] rnd_sat(logic signed [AW-1:0] v);
    logic signed [AW-1:0] t;
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = (AW'(1) <<< (WW - 1)) - AW'(1);
    lo = -(AW'(1) <<< (WW - 1));
    t  = (v + (AW'(1) <<< (qau_pkg::FRAC - 1))) >>> qau_pkg::FRAC;
    if (t > hi) begin
      return {1'b1, hi[WW-1:0]};
    end else if (t < lo) begin
      return {1'b1, lo[WW-1:0]};
    end
    return {1'b0, t[WW-1:0]};
  endfunction

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    a_arr[0] = in_data_i.a_w;
    a_arr[1] = in_data_i.a_x;
    a_arr[2] = in_data_i.a_y;
    a_arr[3] = in_data_i.a_z;
    if (in_data_i.mode == qau_pkg::MODE_MUL) begin
      op_arr[0] = in_data_i.b_w;
      op_arr[1] = in_data_i.b_x;
      op_arr[2] = in_data_i.b_y;
      op_arr[3] = in_data_i.b_z;
    end else begin
      op_arr = a_arr;
    end
    for (int i = 0; i < 4; i++) begin
      neg_d[i] = a_arr[i][WW-1];
      mag_d[i] = neg_d[i] ? WW'(-a_arr[i]) : WW'(a_arr[i]);
      for (int j = 0; j < 4; j++) begin
        prod_d[i][j] = a_arr[i] * op_arr[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        e[i][j] = AW'(prod_q[i][j]);
      end
    end
    c01 = (mode1_q == qau_pkg::MODE_INV) ? -e[0][1] : e[0][1];
    c02 = (mode1_q == qau_pkg::MODE_INV) ? -e[0][2] : e[0][2];
    c03 = (mode1_q == qau_pkg::MODE_INV) ? -e[0][3] : e[0][3];
    if (mode1_q == qau_pkg::MODE_MUL) begin
      acc_d[0] = e[0][0] - e[1][1] - e[2][2] - e[3][3];
      acc_d[1] = e[0][1] + e[1][0] + e[2][3] - e[3][2];
      acc_d[2] = e[0][2] + e[2][0] + e[3][1] - e[1][3];
      acc_d[3] = e[0][3] + e[3][0] + e[1][2] - e[2][1];
      for (int w = 4; w < 9; w++) begin
        acc_d[w] = '0;
      end
    end else begin
      acc_d[0] = e[0][0] + e[1][1] - e[2][2] - e[3][3];
      acc_d[1] = (e[1][2] + c03) <<< 1;
      acc_d[2] = (e[1][3] - c02) <<< 1;
      acc_d[3] = (e[1][2] - c03) <<< 1;
      acc_d[4] = e[0][0] - e[1][1] + e[2][2] - e[3][3];
      acc_d[5] = (e[2][3] + c01) <<< 1;
      acc_d[6] = (e[1][3] + c02) <<< 1;
      acc_d[7] = (e[2][3] - c01) <<< 1;
      acc_d[8] = e[0][0] - e[1][1] - e[2][2] + e[3][3];
    end
    // Squares are never negative, so the sum is taken unsigned.
    rad_d = {2'b00, prod_q[0][0]} + {2'b00, prod_q[1][1]}
          + {2'b00, prod_q[2][2]} + {2'b00, prod_q[3][3]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en) begin
      vld1_q <= in_valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q  <= prod_d;
      mode1_q <= in_data_i.mode;
      mag1_q  <= mag_d;
      neg1_q  <= neg_d;
      acc_q   <= acc_d;
      rad_q   <= rad_d;
      mode2_q <= mode1_q;
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
    end
  end

  always_comb begin
    for (int w = 0; w < 9; w++) begin
      rs[w]           = rnd_sat(acc_q[w]);
      satv[w]         = rs[w][WW];
      side3_d.res[w]  = rs[w][WW-1:0];
    end
    side3_d.mode = mode2_q;
    side3_d.sat  = (mode2_q == qau_pkg::MODE_MUL) ? |satv[3:0] : |satv;
    side3_d.zero = (rad_q == '0);
    side3_d.mag  = mag2_q;
    side3_d.neg  = neg2_q;
  end

  qau_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vld2_q),
    .radicand_i (rad_q),
    .side_i     (side3_d),
    .valid_o    (sq_vld),
    .root_o     (sq_root),
    .side_o     (sq_side)
  );

  qau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .root_i  (sq_root),
    .side_i  (sq_side),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nval[i] = dv_side.neg[i] ? -$signed({2'b00, dv_quo[i]}) : $signed({2'b00, dv_quo[i]});
      nsat[i] = !((nval[i][QW+1:WW-1] == '0) || (nval[i][QW+1:WW-1] == '1));
      if (!nsat[i]) begin
        nres[i] = nval[i][WW-1:0];
      end else if (nval[i][QW+1]) begin
        nres[i] = {1'b1, {(WW-1){1'b0}}};
      end else begin
        nres[i] = {1'b0, {(WW-1){1'b1}}};
      end
    end
    if (dv_side.mode == qau_pkg::MODE_NORM) begin
      fin = '0;
      if (dv_side.zero) begin
        fin_status = qau_pkg::ST_ZERO;
      end else begin
        fin[3:0]   = nres;
        fin_status = (|nsat) ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
      end
    end else begin
      fin        = dv_side.res;
      fin_status = dv_side.sat ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
    end
    out_d.res_0  = fin[0];
    out_d.res_1  = fin[1];
    out_d.res_2  = fin[2];
    out_d.res_3  = fin[3];
    out_d.res_4  = fin[4];
    out_d.res_5  = fin[5];
    out_d.res_6  = fin[6];
    out_d.res_7  = fin[7];
    out_d.res_8  = fin[8];
    out_d.status = fin_status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // A nonzero quaternion never normalizes past one in any part.
  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld && (dv_side.mode == qau_pkg::MODE_NORM) && !dv_side.zero |->
      (dv_quo[0] <= (QW'(1) << qau_pkg::FRAC)) && (dv_quo[1] <= (QW'(1) << qau_pkg::FRAC)) &&
      (dv_quo[2] <= (QW'(1) << qau_pkg::FRAC)) && (dv_quo[3] <= (QW'(1) << qau_pkg::FRAC)))
    else $error("normalized part above one");

  // The product mode leaves the matrix-only words at zero.
  a_mul_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld && (dv_side.mode == qau_pkg::MODE_MUL) |-> (dv_side.res[8:4] == '0))
    else $error("unused words not zero in product mode");

  // A zero-quaternion status comes with an all-zero quaternion.
  a_zero_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == qau_pkg::ST_ZERO) |->
      (out_data_o.res_0 == '0) && (out_data_o.res_1 == '0) &&
      (out_data_o.res_2 == '0) && (out_data_o.res_3 == '0))
    else $error("zero status with nonzero result");
`endif

endmodule
